// ===== hw/rtl/mau_pkg.sv =====
package mau_pkg;

  localparam int MOD_W  = 31;
  localparam int DATA_W = 32;
  localparam int EXP_W  = 64;
  localparam int ACT_W  = 4;
  localparam int OP_W   = 5;
  localparam int CNT_W  = 7;

  localparam logic [MOD_W-1:0] RESET_MOD = 31'd998244353;
  localparam logic [MOD_W-1:0] MOD_MASK  = 31'h7FFF_FFFF;

  localparam logic [CNT_W-1:0] LEN_SHORT = 7'd32;
  localparam logic [CNT_W-1:0] LEN_LONG  = 7'd64;

  localparam logic [ACT_W-1:0] ACT_ADD = 4'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 4'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 4'd2;
  localparam logic [ACT_W-1:0] ACT_NEG = 4'd3;
  localparam logic [ACT_W-1:0] ACT_INC = 4'd4;
  localparam logic [ACT_W-1:0] ACT_DEC = 4'd5;
  localparam logic [ACT_W-1:0] ACT_INV = 4'd6;
  localparam logic [ACT_W-1:0] ACT_DIV = 4'd7;
  localparam logic [ACT_W-1:0] ACT_POW = 4'd8;

  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH    = 5'd1;
  localparam logic [OP_W-1:0] OP_RCP_GO   = 5'd2;
  localparam logic [OP_W-1:0] OP_RCP_LOAD = 5'd3;
  localparam logic [OP_W-1:0] OP_DIV_A    = 5'd4;
  localparam logic [OP_W-1:0] OP_A_LOAD   = 5'd5;
  localparam logic [OP_W-1:0] OP_DIV_B    = 5'd6;
  localparam logic [OP_W-1:0] OP_B_LOAD   = 5'd7;
  localparam logic [OP_W-1:0] OP_SIMPLE   = 5'd8;
  localparam logic [OP_W-1:0] OP_MUL_AB   = 5'd9;
  localparam logic [OP_W-1:0] OP_RES_MM   = 5'd10;
  localparam logic [OP_W-1:0] OP_INV_INIT = 5'd11;
  localparam logic [OP_W-1:0] OP_INV_ZERO = 5'd12;
  localparam logic [OP_W-1:0] OP_DIV_ST   = 5'd13;
  localparam logic [OP_W-1:0] OP_EU_MUL   = 5'd14;
  localparam logic [OP_W-1:0] OP_EU_UPD   = 5'd15;
  localparam logic [OP_W-1:0] OP_INV_FAIL = 5'd16;
  localparam logic [OP_W-1:0] OP_MUL_AC0  = 5'd17;
  localparam logic [OP_W-1:0] OP_RES_C0   = 5'd18;
  localparam logic [OP_W-1:0] OP_POW_INIT = 5'd19;
  localparam logic [OP_W-1:0] OP_POW_MUL  = 5'd20;
  localparam logic [OP_W-1:0] OP_ACC_LOAD = 5'd21;
  localparam logic [OP_W-1:0] OP_POW_SQ   = 5'd22;
  localparam logic [OP_W-1:0] OP_BASE_LOAD = 5'd23;
  localparam logic [OP_W-1:0] OP_RES_ACC  = 5'd24;
  localparam logic [OP_W-1:0] OP_OUT_LOAD = 5'd25;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic             div_done;
    logic             mm_done;
    logic             t_zero;
    logic             x_zero;
    logic             s_one;
    logic             e_zero;
    logic             e_lsb;
    logic             out_free;
    logic             cfg_load;
    logic [ACT_W-1:0] act;
  } dp_sts_t;

endpackage

// ===== hw/rtl/mau_div.sv =====
module mau_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 dividend,
  input  logic [mau_pkg::DATA_W-1:0]  divisor,
  input  logic [mau_pkg::CNT_W-1:0]   len,
  output logic                        done,
  output logic [63:0]                 quo,
  output logic [mau_pkg::DATA_W-1:0]  rem
);

  logic                        busy;
  logic [mau_pkg::CNT_W-1:0]   cnt;
  logic [63:0]                 sr;
  logic [mau_pkg::DATA_W-1:0]  dvs;
  logic [mau_pkg::DATA_W:0]    trial;
  logic                        ge;

  assign trial = {rem, sr[63]};
  assign ge    = trial >= {1'b0, dvs};
  assign quo   = sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= len;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr  <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      sr  <= {sr[62:0], ge};
      rem <= ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
    end
  end

endmodule

// ===== hw/rtl/mau_mm.sv =====
module mau_mm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mau_pkg::MOD_W-1:0]  x,
  input  logic [mau_pkg::MOD_W-1:0]  y,
  input  logic [mau_pkg::MOD_W-1:0]  m,
  input  logic [63:0]                recip,
  output logic                       done,
  output logic [mau_pkg::MOD_W-1:0]  res
);

  logic        busy;
  logic [3:0]  step;
  logic [mau_pkg::MOD_W-1:0] xr;
  logic [mau_pkg::MOD_W-1:0] yr;
  logic [63:0] prod;
  logic [63:0] z;
  logic [95:0] acc;
  logic [31:0] mx;
  logic [31:0] my;
  logic [31:0] v;
  logic [31:0] vfix;

  always_comb begin
    case (step[3:1])
      3'd0: begin
        mx = {1'b0, xr};
        my = {1'b0, yr};
      end
      3'd1: begin
        mx = z[31:0];
        my = recip[31:0];
      end
      3'd2: begin
        mx = z[31:0];
        my = recip[63:32];
      end
      3'd3: begin
        mx = z[63:32];
        my = recip[31:0];
      end
      3'd4: begin
        mx = z[63:32];
        my = recip[63:32];
      end
      3'd5: begin
        mx = acc[95:64];
        my = {1'b0, m};
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  assign v    = z[31:0] - prod[31:0];
  assign vfix = ({1'b0, m} <= v) ? v + {1'b0, m} : v;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 4'd1;
      if (step == 4'd11) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x;
      yr <= y;
    end else if (busy) begin
      if (!step[0]) begin
        prod <= mx * my;
      end else begin
        case (step)
          4'd1:  z   <= prod;
          4'd3:  acc <= {32'd0, prod};
          4'd5:  acc <= acc + {prod, 32'd0};
          4'd7:  acc <= acc + {prod, 32'd0};
          4'd9:  acc <= acc + {prod[31:0], 64'd0};
          4'd11: res <= vfix[30:0];
          default: acc <= acc;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/mau_dp.sv =====
module mau_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mau_pkg::MOD_W-1:0]   cfg_data,
  input  logic [127:0]                s_tdata,
  input  logic [mau_pkg::ACT_W-1:0]   s_tuser,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [31:0]                 m_tdata,
  output logic                        m_tuser,
  input  mau_pkg::dp_cmd_t            cmd,
  output mau_pkg::dp_sts_t            sts
);

  logic [mau_pkg::MOD_W-1:0]  m;
  logic [63:0]                recip;
  logic [mau_pkg::ACT_W-1:0]  act;
  logic [mau_pkg::DATA_W-1:0] a;
  logic [mau_pkg::DATA_W-1:0] b;
  logic [mau_pkg::EXP_W-1:0]  e;
  logic [mau_pkg::MOD_W-1:0]  s;
  logic [mau_pkg::MOD_W-1:0]  t;
  logic [mau_pkg::MOD_W-1:0]  c0;
  logic [mau_pkg::MOD_W-1:0]  c1;
  logic [mau_pkg::MOD_W-1:0]  acc;
  logic [mau_pkg::MOD_W-1:0]  base;
  logic [mau_pkg::MOD_W-1:0]  res;
  logic                       err;
  logic                       out_valid;
  logic [mau_pkg::MOD_W-1:0]  out_res;
  logic                       out_err;

  logic [mau_pkg::MOD_W-1:0]  cfg_val;
  logic [mau_pkg::MOD_W-1:0]  x;
  logic [mau_pkg::MOD_W-1:0]  uu;
  logic [mau_pkg::MOD_W-1:0]  simple;
  logic [mau_pkg::MOD_W-1:0]  cdiff;
  logic [31:0]                sum;
  logic [31:0]                inc;

  logic                        div_start;
  logic [63:0]                 div_dd;
  logic [mau_pkg::DATA_W-1:0]  div_ds;
  logic [mau_pkg::CNT_W-1:0]   div_len;
  logic                        div_done;
  logic [63:0]                 div_q;
  logic [mau_pkg::DATA_W-1:0]  div_r;

  logic                        mm_start;
  logic [mau_pkg::MOD_W-1:0]   mm_x;
  logic [mau_pkg::MOD_W-1:0]   mm_y;
  logic                        mm_done;
  logic [mau_pkg::MOD_W-1:0]   mm_res;

  assign cfg_val = cfg_data & mau_pkg::MOD_MASK;
  assign x       = (act == mau_pkg::ACT_DIV) ? b[30:0] : a[30:0];
  assign uu      = (div_q[31:0] == {1'b0, m}) ? '0 : div_q[30:0];
  assign cdiff   = (c0 >= mm_res) ? c0 - mm_res : c0 - mm_res + m;
  assign sum     = {1'b0, a[30:0]} + {1'b0, b[30:0]};
  assign inc     = {1'b0, a[30:0]} + 32'd1;

  always_comb begin
    case (act)
      mau_pkg::ACT_ADD: simple = (sum >= {1'b0, m}) ? 31'(sum - {1'b0, m}) : sum[30:0];
      mau_pkg::ACT_SUB: simple = (a[30:0] >= b[30:0]) ? a[30:0] - b[30:0]
                                                      : a[30:0] - b[30:0] + m;
      mau_pkg::ACT_NEG: simple = (a[30:0] == '0) ? '0 : m - a[30:0];
      mau_pkg::ACT_INC: simple = (inc >= {1'b0, m}) ? 31'(inc - {1'b0, m}) : inc[30:0];
      mau_pkg::ACT_DEC: simple = (a[30:0] == '0) ? m - 31'd1 : a[30:0] - 31'd1;
      default:          simple = '0;
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    div_dd    = {a, 32'd0};
    div_ds    = {1'b0, m};
    div_len   = mau_pkg::LEN_SHORT;
    case (cmd.op)
      mau_pkg::OP_RCP_GO: begin
        div_dd  = '1;
        div_len = mau_pkg::LEN_LONG;
      end
      mau_pkg::OP_DIV_A: div_dd = {a, 32'd0};
      mau_pkg::OP_DIV_B: div_dd = {b, 32'd0};
      mau_pkg::OP_DIV_ST: begin
        div_dd = {1'b0, s, 32'd0};
        div_ds = {1'b0, t};
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    mm_start = 1'b1;
    mm_x     = a[30:0];
    mm_y     = b[30:0];
    case (cmd.op)
      mau_pkg::OP_MUL_AB: mm_y = b[30:0];
      mau_pkg::OP_EU_MUL: begin
        mm_x = c1;
        mm_y = uu;
      end
      mau_pkg::OP_MUL_AC0: mm_y = c0;
      mau_pkg::OP_POW_MUL: begin
        mm_x = acc;
        mm_y = base;
      end
      mau_pkg::OP_POW_SQ: begin
        mm_x = base;
        mm_y = base;
      end
      default: mm_start = 1'b0;
    endcase
  end

  mau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dd),
    .divisor  (div_ds),
    .len      (div_len),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  mau_mm u_mm (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .x     (mm_x),
    .y     (mm_y),
    .m     (m),
    .recip (recip),
    .done  (mm_done),
    .res   (mm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= mau_pkg::RESET_MOD;
    end else if (cfg_we && cfg_val != '0) begin
      m <= cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mau_pkg::OP_LATCH: begin
        act <= s_tuser;
        a   <= s_tdata[31:0];
        b   <= s_tdata[63:32];
        e   <= s_tdata[127:64];
      end
      mau_pkg::OP_RCP_LOAD: recip <= div_q + 64'd1;
      mau_pkg::OP_A_LOAD:   a <= div_r;
      mau_pkg::OP_B_LOAD:   b <= div_r;
      mau_pkg::OP_SIMPLE: begin
        res <= simple;
        err <= 1'b0;
      end
      mau_pkg::OP_RES_MM: begin
        res <= mm_res;
        err <= 1'b0;
      end
      mau_pkg::OP_INV_INIT: begin
        s  <= m;
        t  <= x;
        c0 <= '0;
        c1 <= 31'd1;
      end
      mau_pkg::OP_INV_ZERO: begin
        res <= '0;
        err <= (m != 31'd1);
      end
      mau_pkg::OP_EU_MUL: begin
        s <= t;
        t <= div_r[30:0];
      end
      mau_pkg::OP_EU_UPD: begin
        c0 <= c1;
        c1 <= cdiff;
      end
      mau_pkg::OP_INV_FAIL: begin
        res <= '0;
        err <= 1'b1;
      end
      mau_pkg::OP_RES_C0: begin
        res <= c0;
        err <= 1'b0;
      end
      mau_pkg::OP_POW_INIT: begin
        acc  <= (m == 31'd1) ? '0 : 31'd1;
        base <= a[30:0];
      end
      mau_pkg::OP_ACC_LOAD: acc <= mm_res;
      mau_pkg::OP_BASE_LOAD: begin
        base <= mm_res;
        e    <= e >> 1;
      end
      mau_pkg::OP_RES_ACC: begin
        res <= acc;
        err <= 1'b0;
      end
      default: res <= res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == mau_pkg::OP_OUT_LOAD) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mau_pkg::OP_OUT_LOAD) begin
      out_res <= res;
      out_err <= err;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res};
  assign m_tuser  = out_err;

  assign sts.div_done = div_done;
  assign sts.mm_done  = mm_done;
  assign sts.t_zero   = (t == '0);
  assign sts.x_zero   = (x == '0);
  assign sts.s_one    = (s == 31'd1);
  assign sts.e_zero   = (e == '0);
  assign sts.e_lsb    = e[0];
  assign sts.out_free = !out_valid || m_tready;
  assign sts.cfg_load = cfg_we && (cfg_val != '0);
  assign sts.act      = act;

endmodule

// ===== hw/rtl/mau_ctrl.sv =====
module mau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  mau_pkg::dp_sts_t  sts,
  output mau_pkg::dp_cmd_t  cmd
);

  localparam logic [4:0] S_RCP_GO    = 5'd0;
  localparam logic [4:0] S_RCP_W     = 5'd1;
  localparam logic [4:0] S_IDLE      = 5'd2;
  localparam logic [4:0] S_RA_GO     = 5'd3;
  localparam logic [4:0] S_RA_W      = 5'd4;
  localparam logic [4:0] S_RB_GO     = 5'd5;
  localparam logic [4:0] S_RB_W      = 5'd6;
  localparam logic [4:0] S_DISP      = 5'd7;
  localparam logic [4:0] S_MUL_W     = 5'd8;
  localparam logic [4:0] S_EU_CHK    = 5'd9;
  localparam logic [4:0] S_EU_DIV_W  = 5'd10;
  localparam logic [4:0] S_EU_MM_W   = 5'd11;
  localparam logic [4:0] S_EU_END    = 5'd12;
  localparam logic [4:0] S_POW_CHK   = 5'd13;
  localparam logic [4:0] S_PA_W      = 5'd14;
  localparam logic [4:0] S_PS_GO     = 5'd15;
  localparam logic [4:0] S_PS_W      = 5'd16;
  localparam logic [4:0] S_OUT       = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  assign s_tready = (state == S_IDLE) && !sts.cfg_load;

  always_comb begin
    state_next = state;
    cmd.op     = mau_pkg::OP_NONE;
    case (state)
      S_RCP_GO: begin
        cmd.op     = mau_pkg::OP_RCP_GO;
        state_next = S_RCP_W;
      end
      S_RCP_W: begin
        if (sts.div_done) begin
          cmd.op     = mau_pkg::OP_RCP_LOAD;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.op     = mau_pkg::OP_LATCH;
          state_next = S_RA_GO;
        end
      end
      S_RA_GO: begin
        cmd.op     = mau_pkg::OP_DIV_A;
        state_next = S_RA_W;
      end
      S_RA_W: begin
        if (sts.div_done) begin
          cmd.op     = mau_pkg::OP_A_LOAD;
          state_next = S_RB_GO;
        end
      end
      S_RB_GO: begin
        cmd.op     = mau_pkg::OP_DIV_B;
        state_next = S_RB_W;
      end
      S_RB_W: begin
        if (sts.div_done) begin
          cmd.op     = mau_pkg::OP_B_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.act)
          mau_pkg::ACT_MUL: begin
            cmd.op     = mau_pkg::OP_MUL_AB;
            state_next = S_MUL_W;
          end
          mau_pkg::ACT_INV, mau_pkg::ACT_DIV: begin
            if (sts.x_zero) begin
              cmd.op     = mau_pkg::OP_INV_ZERO;
              state_next = S_OUT;
            end else begin
              cmd.op     = mau_pkg::OP_INV_INIT;
              state_next = S_EU_CHK;
            end
          end
          mau_pkg::ACT_POW: begin
            cmd.op     = mau_pkg::OP_POW_INIT;
            state_next = S_POW_CHK;
          end
          default: begin
            cmd.op     = mau_pkg::OP_SIMPLE;
            state_next = S_OUT;
          end
        endcase
      end
      S_MUL_W: begin
        if (sts.mm_done) begin
          cmd.op     = mau_pkg::OP_RES_MM;
          state_next = S_OUT;
        end
      end
      S_EU_CHK: begin
        if (sts.t_zero) begin
          state_next = S_EU_END;
        end else begin
          cmd.op     = mau_pkg::OP_DIV_ST;
          state_next = S_EU_DIV_W;
        end
      end
      S_EU_DIV_W: begin
        if (sts.div_done) begin
          cmd.op     = mau_pkg::OP_EU_MUL;
          state_next = S_EU_MM_W;
        end
      end
      S_EU_MM_W: begin
        if (sts.mm_done) begin
          cmd.op     = mau_pkg::OP_EU_UPD;
          state_next = S_EU_CHK;
        end
      end
      S_EU_END: begin
        if (!sts.s_one) begin
          cmd.op     = mau_pkg::OP_INV_FAIL;
          state_next = S_OUT;
        end else if (sts.act == mau_pkg::ACT_DIV) begin
          cmd.op     = mau_pkg::OP_MUL_AC0;
          state_next = S_MUL_W;
        end else begin
          cmd.op     = mau_pkg::OP_RES_C0;
          state_next = S_OUT;
        end
      end
      S_POW_CHK: begin
        if (sts.e_zero) begin
          cmd.op     = mau_pkg::OP_RES_ACC;
          state_next = S_OUT;
        end else if (sts.e_lsb) begin
          cmd.op     = mau_pkg::OP_POW_MUL;
          state_next = S_PA_W;
        end else begin
          state_next = S_PS_GO;
        end
      end
      S_PA_W: begin
        if (sts.mm_done) begin
          cmd.op     = mau_pkg::OP_ACC_LOAD;
          state_next = S_PS_GO;
        end
      end
      S_PS_GO: begin
        cmd.op     = mau_pkg::OP_POW_SQ;
        state_next = S_PS_W;
      end
      S_PS_W: begin
        if (sts.mm_done) begin
          cmd.op     = mau_pkg::OP_BASE_LOAD;
          state_next = S_POW_CHK;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op     = mau_pkg::OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (sts.cfg_load) begin
      cmd.op     = mau_pkg::OP_NONE;
      state_next = S_RCP_GO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCP_GO;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// Modular arithmetic unit over a modulus held in a configuration register.
// Config: cfg_we/cfg_data write the 31-bit modulus; a zero value is dropped.
// Each write starts a reciprocal pass; no request is taken meanwhile.
// Input stream: s_tuser carries the action, s_tdata the operands and exponent.
// Output stream: one result per request, residue in m_tdata, error in m_tuser.
// One request is in work at a time; the next one is taken once the result
// has moved to the output register, which holds it while m_tready is low.
// Each request first reduces both operands on the shared bit-serial divider
// (one quotient bit per cycle); products go to the shared 32x32 multiplier:
//   add, sub, neg, inc, dec: no product
//   mul: one product; pow: up to two products per exponent bit
//   inv, div: a division and a product per Euclid step (div adds one product)
// Reset: synchronous, active high; the reset modulus is 998244353 and the
// reciprocal pass runs right after reset, with s_tready low.
module modular_arithmetic_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // operand_a, operand_b, exponent
  input  logic [3:0]   s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // result, zero pad
  output logic         m_tuser    // no_inverse
);

  mau_pkg::dp_cmd_t cmd;
  mau_pkg::dp_sts_t sts;

  mau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mau_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[30:0] == 31'd0)
    else $error("error flag with nonzero residue");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while one is in work");

  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken during reciprocal pass");

endmodule

// ===== sim/tb.sv =====
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [30:0] residue;
    bit        no_inv;
  } residue_t;

  class residue_scoreboard;
    bit [31:0]  modulus;
    bit [63:0]  recip;
    residue_t   expected_q[$];
    int         errors;
    int         checked;

    function new();
      set_modulus(mau_pkg::RESET_MOD);
      errors  = 0;
      checked = 0;
    endfunction

    function void set_modulus(bit [30:0] value);
      if (value != 0) begin
        modulus = {1'b0, value};
        recip   = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, modulus} + 64'd1;
      end
    endfunction

    function bit [31:0] barrett_mul(bit [31:0] a, bit [31:0] b);
      bit [63:0]  z;
      bit [127:0] p;
      bit [63:0]  q;
      bit [63:0]  t;
      bit [31:0]  v;
      z = {32'd0, a} * {32'd0, b};
      p = {64'd0, z} * {64'd0, recip};
      q = p[127:64];
      t = z - q * {32'd0, modulus};
      v = t[31:0];
      if (modulus <= v) v = v + modulus;
      return v;
    endfunction

    function bit euclid_inverse(bit [31:0] a, output bit [31:0] iv);
      longint mm, s, t, c0, c1, u, tmp;
      mm = longint'(modulus);
      if (a == 0) begin
        iv = 0;
        return modulus == 1;
      end
      s = mm; t = longint'(a); c0 = 0; c1 = 1;
      while (t != 0) begin
        u = s / t;
        s = s - t * u;
        c0 = c0 - c1 * u;
        tmp = s; s = t; t = tmp;
        tmp = c0; c0 = c1; c1 = tmp;
      end
      if (c0 < 0) c0 = c0 + mm / s;
      tmp = c0 % mm;
      iv = tmp[31:0];
      return s == 1;
    endfunction

    function bit [31:0] power(bit [31:0] base, bit [63:0] e);
      bit [31:0] acc;
      acc = 32'd1 % modulus;
      while (e != 0) begin
        if (e[0]) acc = barrett_mul(acc, base);
        base = barrett_mul(base, base);
        e = e >> 1;
      end
      return acc;
    endfunction

    function void note_request(bit [3:0] act, bit [31:0] op_a, bit [31:0] op_b,
                               bit [63:0] e);
      bit [31:0] a, b, r, iv;
      residue_t  x;
      a = op_a % modulus;
      b = op_b % modulus;
      r = 0;
      x.no_inv = 0;
      case (act)
        mau_pkg::ACT_ADD: begin
          r = a + b;
          if (r >= modulus) r = r - modulus;
        end
        mau_pkg::ACT_SUB: begin
          r = a - b;
          if (r >= modulus) r = r + modulus;
        end
        mau_pkg::ACT_MUL: r = barrett_mul(a, b);
        mau_pkg::ACT_NEG: r = (a == 0) ? 32'd0 : modulus - a;
        mau_pkg::ACT_INC: begin
          r = a + 1;
          if (r >= modulus) r = r - modulus;
        end
        mau_pkg::ACT_DEC: r = (a == 0) ? modulus - 1 : a - 1;
        mau_pkg::ACT_INV: begin
          if (euclid_inverse(a, iv)) r = iv;
          else x.no_inv = 1;
        end
        mau_pkg::ACT_DIV: begin
          if (euclid_inverse(b, iv)) r = barrett_mul(a, iv);
          else x.no_inv = 1;
        end
        mau_pkg::ACT_POW: r = power(a, e);
        default: r = 0;
      endcase
      x.residue = r[30:0];
      expected_q.push_back(x);
    endfunction

    function void check_result(bit [31:0] data, bit flag);
      residue_t x;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result residue=%0d no_inverse=%0b", $time,
                 data[30:0], flag);
        errors++;
        return;
      end
      x = expected_q.pop_front();
      checked++;
      if (data[30:0] !== x.residue || data[31] !== 1'b0) begin
        $display("%0t: residue mismatch expected %0d actual %0d (tdata %h)", $time,
                 x.residue, data[30:0], data);
        errors++;
      end
      if (flag !== x.no_inv) begin
        $display("%0t: no_inverse mismatch expected %0b actual %0b", $time,
                 x.no_inv, flag);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [30:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [3:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic         m_tuser;

  residue_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int sent;
  int act_count[16];
  int moduli_written;

  modular_arithmetic_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("FAIL modular_arithmetic_unit");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready = 0;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  task automatic send_request(bit [3:0] act, bit [31:0] a, bit [31:0] b, bit [63:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tuser  = act;
    s_tdata  = {e, b, a};
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(act, a, b, e);
    act_count[act]++;
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_modulus(bit [30:0] value);
    drain();
    cfg_we   = 1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 0;
    sb.set_modulus(value);
    moduli_written++;
  endtask

  function automatic bit [31:0] pick_operand(bit [31:0] m);
    case ($urandom_range(5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return m - $urandom_range(2);
      3: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_requests(int n);
    bit [3:0]  act;
    bit [63:0] e;
    repeat (n) begin
      act = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
      if ($urandom_range(19) == 0) e = {$urandom, $urandom};
      else e = {$urandom, $urandom} >> $urandom_range(56, 64);
      send_request(act, pick_operand(sb.modulus), pick_operand(sb.modulus), e);
    end
  endtask

  initial begin
    bit [30:0] mod_list[8];
    int        stall_set[4];
    int        idle_set[4];

    sb = new();
    rst = 1;
    cfg_we = 0;
    cfg_data = 0;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = mau_pkg::ACT_ADD;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    sent = 0;
    moduli_written = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset modulus
    send_request(mau_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(mau_pkg::ACT_ADD, mau_pkg::RESET_MOD - 1, 1, 0);
    send_request(mau_pkg::ACT_SUB, 0, 32'hFFFF_FFFF, 0);
    send_request(mau_pkg::ACT_SUB, 5, 5, 0);
    send_request(mau_pkg::ACT_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(mau_pkg::ACT_MUL, mau_pkg::RESET_MOD - 1, mau_pkg::RESET_MOD - 1, 0);
    send_request(mau_pkg::ACT_NEG, 0, 0, 0);
    send_request(mau_pkg::ACT_NEG, 32'hFFFF_FFFF, 0, 0);
    send_request(mau_pkg::ACT_INC, mau_pkg::RESET_MOD - 1, 0, 0);
    send_request(mau_pkg::ACT_DEC, 0, 0, 0);
    send_request(mau_pkg::ACT_DEC, mau_pkg::RESET_MOD, 0, 0);
    send_request(mau_pkg::ACT_INV, 0, 0, 0);
    send_request(mau_pkg::ACT_INV, 1, 0, 0);
    send_request(mau_pkg::ACT_INV, 32'hFFFF_FFFF, 0, 0);
    send_request(mau_pkg::ACT_DIV, 7, 0, 0);
    send_request(mau_pkg::ACT_DIV, 32'hFFFF_FFFF, 3, 0);
    send_request(mau_pkg::ACT_POW, 3, 0, 0);
    send_request(mau_pkg::ACT_POW, 3, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(mau_pkg::ACT_POW, 0, 0, 0);
    send_request(mau_pkg::ACT_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
    send_request(4'd9, 5, 6, 7);
    send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

    // modulus of one, then a zero write that must be dropped
    write_modulus(1);
    send_request(mau_pkg::ACT_INV, 32'hFFFF_FFFF, 0, 0);
    send_request(mau_pkg::ACT_POW, 5, 0, 0);
    write_modulus(0);
    send_request(mau_pkg::ACT_DIV, 9, 4, 0);

    mod_list = '{31'h7FFF_FFFF, 31'd12, 31'd2, 31'h7FFF_FFFE, 31'd65536,
                 31'd1, 31'd998244353, 31'($urandom) | 31'd1};
    idle_set  = '{0, 83, 0, 16};
    stall_set = '{0, 0, 83, 16};
    foreach (mod_list[i]) begin
      write_modulus(mod_list[i]);
      send_idle_pct  = idle_set[i % 4];
      recv_stall_pct = stall_set[i % 4];
      if (i == 2) hold_cycles = 3000;
      random_requests(i == 5 ? 60 : 170);
      // an arbitrary modulus after every third phase
      if (i % 3 == 2) begin
        write_modulus(31'($urandom));
        random_requests(40);
      end
    end

    drain();
    repeat (200) @(negedge clk);
    $display("Sent %0d requests over %0d modulus writes, %0d results checked",
             sent, moduli_written, sb.checked);
    $display("Per action: add %0d sub %0d mul %0d neg %0d inc %0d dec %0d inv %0d div %0d pow %0d",
             act_count[0], act_count[1], act_count[2], act_count[3], act_count[4],
             act_count[5], act_count[6], act_count[7], act_count[8]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS modular_arithmetic_unit");
    end else begin
      $display("FAIL modular_arithmetic_unit");
    end
    $finish;
  end

endmodule
